@@ design/ordered_list_engine_macros.svh @@
// Assertion macros of the ordered list engine; olst_ctrl is the module that uses them.
// Depends on nothing; included by the files that carry assertions.
`ifndef ORDERED_LIST_ENGINE_MACROS_SVH
`define ORDERED_LIST_ENGINE_MACROS_SVH

// Checks that a condition holds at every clock edge outside reset.
`define OLST_ASSERT_ALWAYS(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("ordered list engine: invariant violated");

// Checks that a condition in one cycle implies another in the next cycle.
`define OLST_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ordered list engine: sequence violated");

`endif

@@ design/olst_pkg.sv @@
// Shared constants and types of the ordered list engine.
// Depends on nothing; imported by every module of the block.
package olst_pkg;

   localparam int OLST_DEPTH = 64;

   localparam logic [2:0] CMD_INSERT_AT   = 3'd0;
   localparam logic [2:0] CMD_INSERT_LAST = 3'd1;
   localparam logic [2:0] CMD_DELETE_AT   = 3'd2;
   localparam logic [2:0] CMD_DELETE_LAST = 3'd3;
   localparam logic [2:0] CMD_SEARCH      = 3'd4;
   localparam logic [2:0] CMD_CLEAR       = 3'd5;

   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_RANGE   = 2'd1;
   localparam logic [1:0] STATUS_FULL    = 2'd2;
   localparam logic [1:0] STATUS_MISSING = 2'd3;

   typedef struct packed {
      logic               valid;
      logic [1:0]         status;
      logic signed [31:0] removed_value;
      logic [5:0]         found_index;
      logic [6:0]         entry_count;
   } olst_result_type;

endpackage

@@ design/olst_mem.sv @@
// Entry storage of the ordered list engine: one write port, one registered read port.
// Depends on olst_pkg.
module olst_mem
   import olst_pkg::*;
#(
   parameter int DEPTH = OLST_DEPTH,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic                clock,
   input  logic                wr_en,
   input  logic [AW-1:0]       wr_addr,
   input  logic signed [31:0]  wr_data,
   input  logic                rd_en,
   input  logic [AW-1:0]       rd_addr,
   output logic signed [31:0]  rd_data
);

   logic signed [31:0] entries [DEPTH];
   logic signed [31:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         entries[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= entries[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ design/olst_ctrl.sv @@
// Command sequencer of the ordered list engine: shifts, searches and counts entries
// one memory access at a time. Depends on olst_pkg and the assertion macro header.
`include "ordered_list_engine_macros.svh"

module olst_ctrl
   import olst_pkg::*;
#(
   parameter int DEPTH = OLST_DEPTH,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic [2:0]          req_command,
   input  logic signed [31:0]  req_value,
   input  logic [7:0]          req_position,
   output logic                mem_wr_en,
   output logic [AW-1:0]       mem_wr_addr,
   output logic signed [31:0]  mem_wr_data,
   output logic                mem_rd_en,
   output logic [AW-1:0]       mem_rd_addr,
   input  logic signed [31:0]  mem_rd_data,
   output olst_result_type     result
);

   localparam int CW = $clog2(DEPTH + 1);
   localparam int LW = (CW > 8) ? CW : 8;

   typedef enum logic [9:0] {
      ST_IDLE     = 10'b0000000001,
      ST_INS      = 10'b0000000010,
      ST_INS_WR   = 10'b0000000100,
      ST_DEL_RD   = 10'b0000001000,
      ST_DEL_CAP  = 10'b0000010000,
      ST_DEL      = 10'b0000100000,
      ST_DEL_WR   = 10'b0001000000,
      ST_SRCH     = 10'b0010000000,
      ST_SRCH_CMP = 10'b0100000000,
      ST_DONE     = 10'b1000000000
   } state_type;

   state_type          state_ff, state_in;
   logic [CW-1:0]      count_ff, count_in;
   logic [CW-1:0]      idx_ff, idx_in;
   logic [CW-1:0]      pos_ff, pos_in;
   logic signed [31:0] value_ff, value_in;
   logic signed [31:0] removed_ff, removed_in;
   logic [1:0]         status_ff, status_in;
   logic [5:0]         found_ff, found_in;
   logic [CW-1:0]      wr_idx;
   logic [CW-1:0]      rd_idx;
   logic [LW-1:0]      req_pos_ext;
   logic [LW-1:0]      count_ext;
   logic               full;

   assign req_pos_ext = LW'(req_position);
   assign count_ext   = LW'(count_ff);
   assign full        = (count_ff == CW'(DEPTH));

   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      idx_in     = idx_ff;
      pos_in     = pos_ff;
      value_in   = value_ff;
      removed_in = removed_ff;
      status_in  = status_ff;
      found_in   = found_ff;
      mem_wr_en  = 1'b0;
      mem_rd_en  = 1'b0;
      wr_idx     = idx_ff;
      rd_idx     = idx_ff;
      mem_wr_data = mem_rd_data;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               value_in   = req_value;
               status_in  = STATUS_OK;
               removed_in = '0;
               found_in   = '0;
               state_in   = ST_DONE;
               case (req_command)
                  CMD_INSERT_AT: begin
                     if (req_pos_ext > count_ext) begin
                        status_in = STATUS_RANGE;
                     end else if (full) begin
                        status_in = STATUS_FULL;
                     end else begin
                        pos_in   = CW'(req_position);
                        idx_in   = count_ff;
                        state_in = ST_INS;
                     end
                  end
                  CMD_INSERT_LAST: begin
                     if (full) begin
                        status_in = STATUS_FULL;
                     end else begin
                        pos_in   = count_ff;
                        idx_in   = count_ff;
                        state_in = ST_INS;
                     end
                  end
                  CMD_DELETE_AT: begin
                     if (req_pos_ext >= count_ext) begin
                        status_in = STATUS_RANGE;
                     end else begin
                        pos_in   = CW'(req_position);
                        state_in = ST_DEL_RD;
                     end
                  end
                  CMD_DELETE_LAST: begin
                     if (count_ff == '0) begin
                        status_in = STATUS_RANGE;
                     end else begin
                        pos_in   = count_ff - CW'(1);
                        state_in = ST_DEL_RD;
                     end
                  end
                  CMD_SEARCH: begin
                     idx_in   = '0;
                     state_in = ST_SRCH;
                  end
                  CMD_CLEAR: begin
                     count_in = '0;
                  end
                  default: begin
                     status_in = STATUS_RANGE;
                  end
               endcase
            end
         end
         ST_INS: begin
            if (idx_ff > pos_ff) begin
               mem_rd_en = 1'b1;
               rd_idx    = idx_ff - CW'(1);
               state_in  = ST_INS_WR;
            end else begin
               mem_wr_en   = 1'b1;
               wr_idx      = pos_ff;
               mem_wr_data = value_ff;
               count_in    = count_ff + CW'(1);
               state_in    = ST_DONE;
            end
         end
         ST_INS_WR: begin
            mem_wr_en = 1'b1;
            wr_idx    = idx_ff;
            idx_in    = idx_ff - CW'(1);
            state_in  = ST_INS;
         end
         ST_DEL_RD: begin
            mem_rd_en = 1'b1;
            rd_idx    = pos_ff;
            state_in  = ST_DEL_CAP;
         end
         ST_DEL_CAP: begin
            removed_in = mem_rd_data;
            idx_in     = pos_ff;
            state_in   = ST_DEL;
         end
         ST_DEL: begin
            if ((idx_ff + CW'(1)) < count_ff) begin
               mem_rd_en = 1'b1;
               rd_idx    = idx_ff + CW'(1);
               state_in  = ST_DEL_WR;
            end else begin
               count_in = count_ff - CW'(1);
               state_in = ST_DONE;
            end
         end
         ST_DEL_WR: begin
            mem_wr_en = 1'b1;
            wr_idx    = idx_ff;
            idx_in    = idx_ff + CW'(1);
            state_in  = ST_DEL;
         end
         ST_SRCH: begin
            if (idx_ff < count_ff) begin
               mem_rd_en = 1'b1;
               rd_idx    = idx_ff;
               state_in  = ST_SRCH_CMP;
            end else begin
               status_in = STATUS_MISSING;
               found_in  = '0;
               state_in  = ST_DONE;
            end
         end
         ST_SRCH_CMP: begin
            if (mem_rd_data == value_ff) begin
               found_in = 6'(idx_ff);
               state_in = ST_DONE;
            end else begin
               idx_in   = idx_ff + CW'(1);
               state_in = ST_SRCH;
            end
         end
         ST_DONE: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff     <= idx_in;
      pos_ff     <= pos_in;
      value_ff   <= value_in;
      removed_ff <= removed_in;
      status_ff  <= status_in;
      found_ff   <= found_in;
   end

   assign mem_wr_addr = wr_idx[AW-1:0];
   assign mem_rd_addr = rd_idx[AW-1:0];
   assign busy        = (state_ff != ST_IDLE);

   assign result.valid         = (state_ff == ST_DONE);
   assign result.status        = status_ff;
   assign result.removed_value = removed_ff;
   assign result.found_index   = found_ff;
   assign result.entry_count   = 7'(count_ff);

   `OLST_ASSERT_ALWAYS(a_count_bound, clock, reset, count_ff <= CW'(DEPTH))
   `OLST_ASSERT_ALWAYS(a_write_bound, clock, reset, !mem_wr_en || (wr_idx < CW'(DEPTH)))
   `OLST_ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy)
   `OLST_ASSERT_NEXT(a_done_single, clock, reset, result.valid, !result.valid && !busy)

endmodule

@@ design/ordered_list_engine.sv @@
// Ordered list engine: keeps an ordered list of up to DEPTH signed 32-bit values and
// runs insert, append, delete, search and clear commands on it, one at a time. A command is
// transferred when start is high and busy is low; busy stays high while it runs. A rejected
// command or a clear goes straight to the result. An insert at position p moves the entries
// from the end down to p up by one place and then writes the value at p; a delete at position
// p captures the entry at p and moves each later entry down by one place; a search compares
// the entries from index 0 on until it finds the value or runs past the last entry. Every
// entry moved or compared takes a read and then a write or compare, since the entry memory
// returns read data in the cycle after the address, from a registered read port.
// The result is shown for exactly one cycle with rsp_strobe high, in the cycle in which busy
// falls; the receiver cannot stall it, so it must take every transfer in that cycle. The next
// command may be transferred in the same cycle as the result strobe.
// Depends on olst_pkg, olst_ctrl and olst_mem.
module ordered_list_engine
   import olst_pkg::*;
#(
   parameter int DEPTH = OLST_DEPTH
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [2:0]         req_command,
   input  logic signed [31:0] req_value,
   input  logic [7:0]         req_position,
   output logic               rsp_strobe,
   output logic [1:0]         rsp_status,
   output logic signed [31:0] rsp_removed_value,
   output logic [5:0]         rsp_found_index,
   output logic [6:0]         rsp_entry_count
);

   localparam int AW = $clog2(DEPTH);

   logic               mem_wr_en;
   logic [AW-1:0]      mem_wr_addr;
   logic signed [31:0] mem_wr_data;
   logic               mem_rd_en;
   logic [AW-1:0]      mem_rd_addr;
   logic signed [31:0] mem_rd_data;
   olst_result_type    result;

   logic               strobe_ff;
   logic [1:0]         status_ff;
   logic signed [31:0] removed_ff;
   logic [5:0]         found_ff;
   logic [6:0]         count_ff;

   olst_ctrl #(
      .DEPTH(DEPTH),
      .AW   (AW)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_command (req_command),
      .req_value   (req_value),
      .req_position(req_position),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data),
      .mem_rd_en   (mem_rd_en),
      .mem_rd_addr (mem_rd_addr),
      .mem_rd_data (mem_rd_data),
      .result      (result)
   );

   olst_mem #(
      .DEPTH(DEPTH),
      .AW   (AW)
   ) u_mem (
      .clock  (clock),
      .wr_en  (mem_wr_en),
      .wr_addr(mem_wr_addr),
      .wr_data(mem_wr_data),
      .rd_en  (mem_rd_en),
      .rd_addr(mem_rd_addr),
      .rd_data(mem_rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= result.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (result.valid) begin
         status_ff  <= result.status;
         removed_ff <= result.removed_value;
         found_ff   <= result.found_index;
         count_ff   <= result.entry_count;
      end
   end

   assign rsp_strobe        = strobe_ff;
   assign rsp_status        = status_ff;
   assign rsp_removed_value = removed_ff;
   assign rsp_found_index   = found_ff;
   assign rsp_entry_count   = count_ff;

endmodule
